/* hdl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and fixed constants for the serial-bus frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Fixed field widths of the ports
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChIdxW  = 4;
  localparam int unsigned ChValW  = 11;

  // Sync byte value after reset
  localparam logic [ByteW-1:0] SyncReset = 8'h0F;

  // One decoded channel as held by an output chain cell
  typedef struct packed {
    logic              valid;
    logic [ChIdxW-1:0] index;
    logic [ChValW-1:0] value;
    logic              last;
  } chan_t;

endpackage

/* hdl/sfd_store_cell.sv */
// ----------------------------------------------------------------------------
// sfd_store_cell
// One payload byte of the frame store. Captures the received byte when the
// frame position matches its own slot.
// ----------------------------------------------------------------------------
module sfd_store_cell
  import sfd_pkg::*;
#(
  parameter int unsigned POS_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [POS_W-1:0] wr_pos_i,
  input  logic [ByteW-1:0] wr_byte_i,
  output logic [ByteW-1:0] next_o
);

  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] byte_d;
  logic             hit;

  // slot IDX holds frame byte IDX+1
  assign hit = wr_en_i && (32'(wr_pos_i) == IDX + 1);

  always_comb begin
    byte_d = byte_q;
    if (hit) begin
      byte_d = wr_byte_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign next_o = byte_d;

endmodule

/* hdl/sfd_out_cell.sv */
// ----------------------------------------------------------------------------
// sfd_out_cell
// One stage of the output chain. Loaded in parallel when a frame completes,
// then hands its channel to the neighbor toward the output on each transfer.
// ----------------------------------------------------------------------------
module sfd_out_cell
  import sfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  chan_t load_data_i,
  input  logic  shift_i,
  input  chan_t next_i,
  output chan_t cur_o
);

  chan_t cur_q;
  chan_t cur_d;

  always_comb begin
    cur_d = cur_q;
    if (load_i) begin
      cur_d = load_data_i;
    end else if (shift_i) begin
      cur_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  assign cur_o = cur_q;

endmodule

/* hdl/sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial-bus frame decoder: assembles bytes into frames and emits the
// unpacked channels.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Bytes are ignored until the sync byte
// arrives; a sync byte anywhere restarts the frame. Payload bytes go straight
// into a row of byte cells addressed by frame position. On the last byte of a
// frame all CHANNEL_COUNT channels are unpacked (plain wiring) and loaded at
// once into a chain of output cells, which then shifts one channel per output
// transfer, so channels leave one per cycle while the sink is ready, from the
// cycle after the frame's last byte. Input runs at one byte per cycle; the only
// input stall is on the last byte of a frame while the previous frame's
// channels are still in the output chain. The sync register is written through
// its own port at any time the block is idle; writes are always taken.
module sbus_frame_decoder
  import sfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES   = 25,
  parameter int unsigned CHANNEL_COUNT = 16,
  parameter int unsigned CHANNEL_BITS  = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ByteW-1:0]  cfg_sync_byte_i,
  // received bytes
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  // decoded channels
  output logic              ch_valid_o,
  input  logic              ch_ready_i,
  output logic [ChIdxW-1:0] channel_index_o,
  output logic [ChValW-1:0] channel_value_o,
  output logic              last_channel_o
);

  localparam int unsigned StoreBytes = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
  localparam int unsigned PosW       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned ValBits    = (CHANNEL_BITS < ChValW) ? CHANNEL_BITS : ChValW;

  logic [ByteW-1:0] sync_q, sync_d;
  logic [PosW-1:0]  pos_q, pos_d;

  logic             rx_fire;
  logic             is_sync;
  logic             take;
  logic [PosW-1:0]  pos_eff;
  logic [PosW-1:0]  pos_inc;
  logic             done;
  logic             out_busy;
  logic             shift;

  logic [StoreBytes*ByteW-1:0] store_nx;
  chan_t                       chain [CHANNEL_COUNT+1];
  chan_t                       load_data [CHANNEL_COUNT];

  // sync register
  assign cfg_ready_o = 1'b1;

  always_comb begin
    sync_d = sync_q;
    if (cfg_valid_i && cfg_ready_o) begin
      sync_d = cfg_sync_byte_i;
    end
  end

  // frame position tracking
  assign out_busy   = chain[0].valid;
  assign rx_ready_o = !(out_busy && (pos_q == PosW'(FRAME_BYTES - 1)));
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign is_sync    = (rx_byte_i == sync_q);
  assign take       = (pos_q != '0) || is_sync;
  assign pos_eff    = is_sync ? '0 : pos_q;
  assign pos_inc    = pos_eff + PosW'(1);
  assign done       = take && (pos_inc == PosW'(FRAME_BYTES));

  always_comb begin
    pos_d = pos_q;
    if (rx_fire && take) begin
      pos_d = done ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
      pos_q  <= '0;
    end else begin
      sync_q <= sync_d;
      pos_q  <= pos_d;
    end
  end

  // payload byte cells
  for (genvar i = 0; i < StoreBytes; i++) begin : g_store
    sfd_store_cell #(
      .POS_W (PosW),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (rx_fire && take),
      .wr_pos_i  (pos_eff),
      .wr_byte_i (rx_byte_i),
      .next_o    (store_nx[i*ByteW +: ByteW])
    );
  end

  // unpack little-endian channels from the store including this byte
  for (genvar k = 0; k < CHANNEL_COUNT; k++) begin : g_unpack
    always_comb begin
      load_data[k]       = '0;
      load_data[k].valid = 1'b1;
      load_data[k].index = ChIdxW'(k);
      load_data[k].last  = (k == CHANNEL_COUNT - 1);
      for (int b = 0; b < ValBits; b++) begin
        load_data[k].value[b] = store_nx[k*CHANNEL_BITS + b];
      end
    end
  end

  // output chain, cell 0 drives the port
  assign shift                = ch_valid_o && ch_ready_i;
  assign chain[CHANNEL_COUNT] = '0;

  for (genvar k = 0; k < CHANNEL_COUNT; k++) begin : g_out
    sfd_out_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (rx_fire && done),
      .load_data_i (load_data[k]),
      .shift_i     (shift),
      .next_i      (chain[k+1]),
      .cur_o       (chain[k])
    );
  end

  assign ch_valid_o      = chain[0].valid;
  assign channel_index_o = chain[0].index;
  assign channel_value_o = chain[0].value;
  assign last_channel_o  = chain[0].last;

endmodule

/* hdl/sfd_checker.sv */
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the decoded channel stream of the frame decoder.
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              ch_valid_o,
  input logic              ch_ready_i,
  input logic [ChIdxW-1:0] channel_index_o,
  input logic              last_channel_o
);

  // last flag only on the final channel number
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid_o && last_channel_o |-> channel_index_o == ChIdxW'(CHANNEL_COUNT - 1))
    else $error("last flag on wrong channel index");

  // a frame always starts at channel zero
  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ch_valid_o) |-> channel_index_o == '0)
    else $error("frame did not start at channel zero");

  // channels follow each other without gaps
  a_next_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid_o && ch_ready_i && !last_channel_o |=>
      ch_valid_o && channel_index_o == $past(channel_index_o) + ChIdxW'(1))
    else $error("channel sequence broken");

  // after the last transfer of a frame the stream goes idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid_o && ch_ready_i && last_channel_o |=> !ch_valid_o)
    else $error("channel valid right after last transfer");

endmodule

bind sbus_frame_decoder sfd_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .ch_valid_o      (ch_valid_o),
  .ch_ready_i      (ch_ready_i),
  .channel_index_o (channel_index_o),
  .last_channel_o  (last_channel_o)
);

/* tb/sv/tb_sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// Self-checking testbench for the serial-bus frame decoder.
// ----------------------------------------------------------------------------
// A short directed table runs first: idle bytes, a frame restart, and a frame
// whose payload is half zeros and half ones. Its expected channels are typed
// in. Random traffic follows under several sync byte settings. It is mostly
// well-formed frames with random payload, plus cut frames, stray sync bytes
// and noise. A shadow decoder predicts every channel transfer. Both sides
// stall in random bursts. Once the sink holds off long enough to back up the
// input, and once the source pauses until all channels have drained.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder;
  import sfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameBytes   = 25;
  localparam int unsigned ChanCount    = 16;
  localparam int unsigned ChanBits     = 11;
  localparam int unsigned PayloadBytes = (ChanCount * ChanBits + 7) / 8;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned ChanMax      = (1 << ChanBits) - 1;

  // One expected channel transfer
  typedef struct {
    logic [ChIdxW-1:0] idx;
    logic [ChValW-1:0] val;
    logic              last;
  } chan_exp_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct {
    logic [ByteW-1:0]  rx;
    bit                typed;
    int unsigned       n_chan;
    logic [ChValW-1:0] lo_val;
    logic [ChValW-1:0] hi_val;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ByteW-1:0]  cfg_sync_byte_i;
  logic              rx_valid_i;
  logic              rx_ready_o;
  logic [ByteW-1:0]  rx_byte_i;
  logic              ch_valid_o;
  logic              ch_ready_i;
  logic [ChIdxW-1:0] channel_index_o;
  logic [ChValW-1:0] channel_value_o;
  logic              last_channel_o;

  // Shadow decoder state
  logic [ByteW-1:0]  sync_shadow;
  int unsigned       frame_pos;
  logic [ByteW-1:0]  payload_shadow [PayloadBytes];

  chan_exp_t         chan_q [$];
  dir_row_t          dir_rows [$];
  int unsigned       mismatches;
  bit                calm;
  bit                hold_req;

  sbus_frame_decoder #(
    .FRAME_BYTES   (FrameBytes),
    .CHANNEL_COUNT (ChanCount),
    .CHANNEL_BITS  (ChanBits)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_sync_byte_i (cfg_sync_byte_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .ch_valid_o      (ch_valid_o),
    .ch_ready_i      (ch_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog
  initial begin : watchdog
    #100_000;
    $display("sbus_frame_decoder test failed");
    $finish;
  end

  // Shadow decoder: feed one accepted byte, queue the channels it completes.
  // Returns 1 when the byte was taken into a frame rather than ignored.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input bit queue_chans);
    logic [PayloadBytes*ByteW-1:0] flat;
    chan_exp_t                     c;
    if (frame_pos == 0 && b != sync_shadow) return 1'b0;
    if (b == sync_shadow) frame_pos = 0;
    if (frame_pos >= 1 && frame_pos <= PayloadBytes) payload_shadow[frame_pos-1] = b;
    frame_pos++;
    if (frame_pos == FrameBytes) begin
      frame_pos = 0;
      for (int i = 0; i < PayloadBytes; i++) flat[i*ByteW +: ByteW] = payload_shadow[i];
      if (queue_chans) begin
        for (int k = 0; k < ChanCount; k++) begin
          c.idx  = ChIdxW'(k);
          c.val  = ChValW'(flat[k*ChanBits +: ChanBits]);
          c.last = (k == ChanCount - 1);
          chan_q.push_back(c);
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Byte source: optional idle burst, then one transfer
  task automatic send_byte(input logic [ByteW-1:0] b, input bit predicted, output bit taken);
    if (!calm && $urandom_range(0, 3) == 0) begin
      if (rx_valid_i) rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    taken = decode_byte(b, predicted);
  endtask

  task automatic rx_idle();
    rx_valid_i <= 1'b0;
  endtask

  // Wait until every queued channel has come out, then let the block settle
  task automatic drain_channels();
    do @(posedge clk_i); while (chan_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [ByteW-1:0] v);
    cfg_valid_i     <= 1'b1;
    cfg_sync_byte_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sync_shadow = v;
  endtask

  task automatic add_row(input logic [ByteW-1:0] rx, input bit typed, input int unsigned n,
                         input logic [ChValW-1:0] lo, input logic [ChValW-1:0] hi);
    dir_row_t r;
    r.rx = rx; r.typed = typed; r.n_chan = n; r.lo_val = lo; r.hi_val = hi;
    dir_rows.push_back(r);
  endtask

  // Random traffic: mostly frames, some cut short or restarted, some noise
  task automatic run_traffic(input int unsigned n_taken);
    int unsigned      used;
    int unsigned      cut;
    logic [ByteW-1:0] b;
    bit               taken;
    used = 0;
    while (used < n_taken) begin
      if ($urandom_range(0, 3) != 0) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
        send_byte(sync_shadow, 1'b1, taken);
        used += taken;
        for (int p = 1; p < cut; p++) begin
          if ($urandom_range(0, 49) == 0) begin
            b = sync_shadow;
          end else begin
            do b = ByteW'($urandom_range(0, 255)); while (b == sync_shadow);
          end
          send_byte(b, 1'b1, taken);
          used += taken;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(ByteW'($urandom_range(0, 255)), 1'b1, taken);
          used += taken;
        end
      end
    end
  endtask

  // Channel sink: random stalls, one long hold on request
  initial begin : ch_sink
    ch_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        ch_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        ch_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        ch_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Channel checker
  always @(posedge clk_i) begin : ch_check
    chan_exp_t want;
    if (rst_ni && ch_valid_o && ch_ready_i) begin
      if (chan_q.size() == 0) begin
        note_mismatch($sformatf("unexpected channel idx=%0d val=%0d last=%0b",
                                channel_index_o, channel_value_o, last_channel_o));
      end else begin
        want = chan_q.pop_front();
        if (channel_index_o !== want.idx || channel_value_o !== want.val ||
            last_channel_o !== want.last) begin
          note_mismatch($sformatf("exp idx=%0d val=%0d last=%0b, got idx=%0d val=%0d last=%0b",
                                  want.idx, want.val, want.last,
                                  channel_index_o, channel_value_o, last_channel_o));
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    chan_exp_t c;
    bit        taken;
    rst_ni          = 1'b0;
    rx_valid_i      = 1'b0;
    rx_byte_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_sync_byte_i = '0;
    mismatches      = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    sync_shadow     = SyncReset;
    frame_pos       = 0;

    // Directed: idle bytes ignored, restart inside a frame, then a frame whose
    // low eight channels are all zero and high eight all ones
    add_row(8'h00, 1'b1, 0, '0, '0);
    add_row(8'hFF, 1'b1, 0, '0, '0);
    add_row(SyncReset, 1'b0, 0, '0, '0);
    add_row(8'hAA, 1'b0, 0, '0, '0);
    add_row(8'h55, 1'b0, 0, '0, '0);
    add_row(SyncReset, 1'b0, 0, '0, '0);
    repeat (PayloadBytes / 2) add_row(8'h00, 1'b0, 0, '0, '0);
    repeat (PayloadBytes / 2) add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b1, ChanCount, '0, ChValW'(ChanMax));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      send_byte(dir_rows[r].rx, !dir_rows[r].typed, taken);
      if (dir_rows[r].typed) begin
        for (int k = 0; k < dir_rows[r].n_chan; k++) begin
          c.idx  = ChIdxW'(k);
          c.val  = (k < ChanCount / 2) ? dir_rows[r].lo_val : dir_rows[r].hi_val;
          c.last = (k == ChanCount - 1);
          chan_q.push_back(c);
        end
      end
    end

    // Sync 0x00, with a long sink hold while bytes keep coming
    rx_idle();
    drain_channels();
    write_sync(8'h00);
    hold_req = 1'b1;
    run_traffic(90);

    // Sync 0xFF, source pauses mid-phase until everything has drained
    rx_idle();
    drain_channels();
    write_sync(8'hFF);
    run_traffic(45);
    rx_idle();
    drain_channels();
    run_traffic(45);

    // Random sync value
    rx_idle();
    drain_channels();
    write_sync(ByteW'($urandom_range(1, 254)));
    run_traffic(90);

    // Back to the reset value, no idling on either side
    rx_idle();
    drain_channels();
    write_sync(SyncReset);
    calm = 1'b1;
    run_traffic(90);

    rx_idle();
    drain_channels();
    repeat (20) @(posedge clk_i);
    if (chan_q.size() != 0) begin
      note_mismatch($sformatf("%0d channels never arrived", chan_q.size()));
    end
    if (mismatches == 0 && chan_q.size() == 0) begin
      $display("sbus_frame_decoder test passed");
    end else begin
      $display("sbus_frame_decoder test failed");
    end
    $finish;
  end

endmodule
